>>> design/value_histogram_binner_top_macros.svh
// assertion macros for the histogram binner, clocked on clk, off during reset
`ifndef VALUE_HISTOGRAM_BINNER_TOP_MACROS_SVH
`define VALUE_HISTOGRAM_BINNER_TOP_MACROS_SVH

// consequent checked in the same cycle
`define VHB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define VHB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/vhb_pkg.sv
package vhb_pkg;

    localparam int ValueWidth    = 32;
    localparam int CountWidth    = 11;
    localparam int BucketWidth   = 10;
    localparam int KindWidth     = 2;
    localparam int CfgIndexWidth = 2;
    localparam int ProductWidth  = ValueWidth + CountWidth;
    localparam int StepWidth     = $clog2(CountWidth);

    localparam int DEF_MAX_BUCKETS = 1024;

    // command kinds
    localparam logic [KindWidth-1:0] KIND_ADD   = 2'd0;
    localparam logic [KindWidth-1:0] KIND_READ  = 2'd1;
    localparam logic [KindWidth-1:0] KIND_CLEAR = 2'd2;

    // register indexes
    localparam logic [CfgIndexWidth-1:0] REG_RANGE_MIN    = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_RANGE_MAX    = 2'd1;
    localparam logic [CfgIndexWidth-1:0] REG_BUCKET_COUNT = 2'd2;

    // register reset values
    localparam logic [ValueWidth-1:0] RANGE_MIN_RESET    = 32'sd0;
    localparam logic [ValueWidth-1:0] RANGE_MAX_RESET    = 32'sd65536;
    localparam logic [CountWidth-1:0] BUCKET_COUNT_RESET = 11'd50;

    localparam logic [ValueWidth-1:0] VALUE_MOST_POS = {1'b0, {(ValueWidth-1){1'b1}}};
    localparam logic [ValueWidth-1:0] VALUE_MOST_NEG = {1'b1, {(ValueWidth-1){1'b0}}};
    localparam logic [ValueWidth-1:0] COUNT_SAT      = {ValueWidth{1'b1}};

endpackage

>>> design/vhb_if.sv
// command channel
interface vhb_item_if import vhb_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [KindWidth-1:0]         kind;
    logic signed [ValueWidth-1:0] sample_value;
    logic [BucketWidth-1:0]       bucket_index;

    modport source (output valid, kind, sample_value, bucket_index, input ready);
    modport sink   (input valid, kind, sample_value, bucket_index, output ready);
endinterface

// result channel
interface vhb_out_if import vhb_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [BucketWidth-1:0]       bucket;
    logic                         counted;
    logic [ValueWidth-1:0]        bucket_total;
    logic [ValueWidth-1:0]        largest_count;
    logic [ValueWidth-1:0]        total_counted;
    logic signed [ValueWidth-1:0] seen_low;
    logic signed [ValueWidth-1:0] seen_high;
    logic                         bad_range;

    modport source (output valid, bucket, counted, bucket_total, largest_count,
                    total_counted, seen_low, seen_high, bad_range, input ready);
    modport sink   (input valid, bucket, counted, bucket_total, largest_count,
                    total_counted, seen_low, seen_high, bad_range, output ready);
endinterface

// register write channel
interface vhb_cfg_if import vhb_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CfgIndexWidth-1:0] index;
    logic [ValueWidth-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/value_histogram_binner_top.sv
// Equal-width histogram engine over signed Q16.16 samples. An add command places the sample
// in bucket floor((v - range_min) * bucket_count / (range_max - range_min)), a sample equal to
// range_max landing in the last bucket, and bumps that bucket's count and the running total
// (both saturate at 2^32-1); samples outside the range, a range with range_max not above
// range_min, or a bucket count of 0 or above MAX_BUCKETS count nothing, while the observed
// minimum and maximum follow every add command. A read command returns one bucket's count, a
// clear command zeroes the store and the running values. Every command gives exactly one result
// transaction. The bucket index comes from one 32x11 multiply followed by a restoring divider
// that retires one quotient bit per cycle, and the counts live in a memory of MAX_BUCKETS
// words with one write port and a registered read port. A command is accepted only in the
// idle state, so a new command waits until the previous one has finished. A clear sweeps the
// memory one word a cycle; the same sweep runs after reset, during which no command is
// accepted (register writes are taken at any time). A finished result waits in the output
// register while the next command is accepted.
`include "value_histogram_binner_top_macros.svh"

module value_histogram_binner_top import vhb_pkg::*; #(
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS
) (
    input  logic          clk,
    input  logic          rst_n,
    vhb_item_if.sink      item,
    vhb_out_if.source     result,
    vhb_cfg_if.sink       cfg
);

    localparam int AddrWidth = $clog2(MAX_BUCKETS);

    // sequencer codes
    localparam logic [3:0] S_SWEEP = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PREP  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_CLAMP = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // configuration registers
    logic signed [ValueWidth-1:0] min_reg;
    logic signed [ValueWidth-1:0] max_reg;
    logic [CountWidth-1:0]        bc_reg;

    // sequencer and datapath
    logic [3:0]                   state_reg,  state_next;
    logic [KindWidth-1:0]         kind_reg,   kind_next;
    logic signed [ValueWidth-1:0] value_reg,  value_next;
    logic [CountWidth-1:0]        idx_reg,    idx_next;
    logic [ValueWidth-1:0]        diff_reg,   diff_next;
    logic [ValueWidth-1:0]        span_reg,   span_next;
    logic [ProductWidth-1:0]      rem_reg,    rem_next;
    logic [ProductWidth-1:0]      dvs_reg,    dvs_next;
    logic [CountWidth-1:0]        quot_reg,   quot_next;
    logic [StepWidth-1:0]         step_reg,   step_next;
    logic [AddrWidth-1:0]         sweep_reg,  sweep_next;
    logic                         clr_res_reg, clr_res_next;
    logic                         counted_reg, counted_next;
    logic [ValueWidth-1:0]        total_reg,  total_next;

    // running values
    logic [ValueWidth-1:0]        peak_reg,   peak_next;
    logic [ValueWidth-1:0]        sum_reg,    sum_next;
    logic signed [ValueWidth-1:0] low_reg,    low_next;
    logic signed [ValueWidth-1:0] high_reg,   high_next;

    // output register
    logic                         out_valid_reg;
    logic [BucketWidth-1:0]       out_bucket_reg;
    logic                         out_counted_reg;
    logic [ValueWidth-1:0]        out_total_reg;
    logic [ValueWidth-1:0]        out_peak_reg;
    logic [ValueWidth-1:0]        out_sum_reg;
    logic signed [ValueWidth-1:0] out_low_reg;
    logic signed [ValueWidth-1:0] out_high_reg;
    logic                         out_bad_reg;

    // count memory
    logic [ValueWidth-1:0]        mem [MAX_BUCKETS];
    logic [ValueWidth-1:0]        rd_data_reg;
    logic [AddrWidth-1:0]         rd_addr;
    logic                         mem_we;
    logic [AddrWidth-1:0]         mem_wa;
    logic [ValueWidth-1:0]        mem_wd;

    logic                         accept;
    logic                         load_out;
    logic                         bad;
    logic                         bc_ok;
    logic                         in_range;
    logic                         in_store;
    logic                         div_ge;
    logic [ValueWidth-1:0]        bumped;

    assign accept   = item.valid && item.ready;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    // range checks against the live registers; keeping them stable while a command runs is up to the user
    assign bad      = !(max_reg > min_reg);
    assign bc_ok    = (bc_reg != '0) && (32'(bc_reg) <= 32'(MAX_BUCKETS));
    assign in_range = !bad && bc_ok && (value_reg >= min_reg) && (value_reg <= max_reg);
    assign in_store = 32'(idx_reg) < 32'(MAX_BUCKETS);

    // the shared compare/subtract of the divider
    assign div_ge   = rem_reg >= dvs_reg;

    assign bumped   = (rd_data_reg == COUNT_SAT) ? rd_data_reg : rd_data_reg + 1'b1;
    assign rd_addr  = AddrWidth'(idx_reg);

    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= RANGE_MIN_RESET;
            max_reg <= RANGE_MAX_RESET;
            bc_reg  <= BUCKET_COUNT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_RANGE_MIN:    min_reg <= cfg.data;
                REG_RANGE_MAX:    max_reg <= cfg.data;
                REG_BUCKET_COUNT: bc_reg  <= cfg.data[CountWidth-1:0];
                default:          ;
            endcase
        end
    end

    // memory write port: sweep zeroes, update stores the bumped count
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = sweep_reg;
        mem_wd = '0;
        if (state_reg == S_SWEEP)
        begin
            mem_we = 1'b1;
        end
        else if ((state_reg == S_UPD) && (kind_reg == KIND_ADD))
        begin
            mem_we = 1'b1;
            mem_wa = rd_addr;
            mem_wd = bumped;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        value_next   = value_reg;
        idx_next     = idx_reg;
        diff_next    = diff_reg;
        span_next    = span_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        quot_next    = quot_reg;
        step_next    = step_reg;
        sweep_next   = sweep_reg;
        clr_res_next = clr_res_reg;
        counted_next = counted_reg;
        total_next   = total_reg;
        peak_next    = peak_reg;
        sum_next     = sum_reg;
        low_next     = low_reg;
        high_next    = high_reg;

        case (state_reg)
            S_SWEEP:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AddrWidth'(MAX_BUCKETS - 1))
                begin
                    state_next = clr_res_reg ? S_DONE : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next    = item.kind;
                    value_next   = item.sample_value;
                    idx_next     = {1'b0, item.bucket_index};
                    counted_next = 1'b0;
                    total_next   = '0;
                    state_next   = S_PREP;
                end
            end

            S_PREP:
            begin
                case (kind_reg)
                    KIND_ADD:
                    begin
                        if (value_reg < low_reg)
                        begin
                            low_next = value_reg;
                        end
                        if (value_reg > high_reg)
                        begin
                            high_next = value_reg;
                        end
                        // for an in-range sample both differences are non-negative and fit unsigned
                        diff_next = value_reg - min_reg;
                        span_next = max_reg - min_reg;
                        if (in_range)
                        begin
                            state_next = S_MUL;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_DONE;
                        end
                    end
                    KIND_READ:
                    begin
                        state_next = in_store ? S_RD : S_DONE;
                    end
                    KIND_CLEAR:
                    begin
                        idx_next     = '0;
                        peak_next    = '0;
                        sum_next     = '0;
                        low_next     = VALUE_MOST_POS;
                        high_next    = VALUE_MOST_NEG;
                        sweep_next   = '0;
                        clr_res_next = 1'b1;
                        state_next   = S_SWEEP;
                    end
                    default:
                    begin
                        idx_next   = '0;
                        state_next = S_DONE;
                    end
                endcase
            end

            S_MUL:
            begin
                rem_next   = ProductWidth'(diff_reg) * ProductWidth'(bc_reg);
                dvs_next   = ProductWidth'(span_reg) << (CountWidth - 1);
                quot_next  = '0;
                step_next  = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                // quotient never exceeds bucket_count, so 11 bits suffice
                if (div_ge)
                begin
                    rem_next = rem_reg - dvs_reg;
                end
                quot_next = {quot_reg[CountWidth-2:0], div_ge};
                dvs_next  = dvs_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == StepWidth'(CountWidth - 1))
                begin
                    state_next = S_CLAMP;
                end
            end

            S_CLAMP:
            begin
                // sample at range_max lands in the last bucket
                idx_next   = (quot_reg >= bc_reg) ? bc_reg - 1'b1 : quot_reg;
                state_next = S_RD;
            end

            S_RD:
            begin
                state_next = S_UPD;
            end

            S_UPD:
            begin
                if (kind_reg == KIND_ADD)
                begin
                    counted_next = 1'b1;
                    total_next   = bumped;
                    if (sum_reg != COUNT_SAT)
                    begin
                        sum_next = sum_reg + 1'b1;
                    end
                    if (bumped > peak_reg)
                    begin
                        peak_next = bumped;
                    end
                end
                else
                begin
                    total_next = rd_data_reg;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (load_out)
                begin
                    clr_res_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_SWEEP;
            sweep_reg   <= '0;
            clr_res_reg <= 1'b0;
            step_reg    <= '0;
            peak_reg    <= '0;
            sum_reg     <= '0;
            low_reg     <= VALUE_MOST_POS;
            high_reg    <= VALUE_MOST_NEG;
        end
        else
        begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            clr_res_reg <= clr_res_next;
            step_reg    <= step_next;
            peak_reg    <= peak_next;
            sum_reg     <= sum_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
        end
    end

    // datapath payload, no reset
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        value_reg   <= value_next;
        idx_reg     <= idx_next;
        diff_reg    <= diff_next;
        span_reg    <= span_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        quot_reg    <= quot_next;
        counted_reg <= counted_next;
        total_reg   <= total_next;
    end

    // output register, holds a finished result until the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_bucket_reg  <= idx_reg[BucketWidth-1:0];
            out_counted_reg <= counted_reg;
            out_total_reg   <= total_reg;
            out_peak_reg    <= peak_reg;
            out_sum_reg     <= sum_reg;
            out_low_reg     <= low_reg;
            out_high_reg    <= high_reg;
            out_bad_reg     <= bad;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.bucket        = out_bucket_reg;
    assign result.counted       = out_counted_reg;
    assign result.bucket_total  = out_total_reg;
    assign result.largest_count = out_peak_reg;
    assign result.total_counted = out_sum_reg;
    assign result.seen_low      = out_low_reg;
    assign result.seen_high     = out_high_reg;
    assign result.bad_range     = out_bad_reg;

    // a result is only ever loaded from the final step
    `VHB_ASSERT_NOW(a_result_from_done, $rose(out_valid_reg), $past(state_reg) == S_DONE, "result loaded outside done step")
    // the divider quotient must not run past the bucket count
    `VHB_ASSERT_NOW(a_quot_bounded, state_reg == S_CLAMP, quot_reg <= bc_reg, "quotient above bucket count")
    // no bucket can hold more than the total counted
    `VHB_ASSERT_NOW(a_peak_le_sum, 1'b1, peak_reg <= sum_reg, "largest count above total counted")
    // a counted sample leaves a non-zero bucket count
    `VHB_ASSERT_NOW(a_counted_nonzero, result.valid && result.counted, result.bucket_total != '0, "counted sample with empty bucket")

endmodule
